### design/gtos_pkg.sv
// ----------------------------------------------------------------------------
// gtos_pkg
// Types and codes shared by the track overlap suppression block.
// ----------------------------------------------------------------------------
package gtos_pkg;

  localparam int WEIGHT_W      = 16;
  localparam int CLUSTER_IN_W  = 8;
  localparam int TRACK_INDEX_W = 6;
  localparam int STATUS_W      = 2;

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // track status codes
  localparam logic [STATUS_W-1:0] ST_UNASSIGNED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SELECTED   = 2'd2;

  // register map (word index bit of paddr)
  localparam logic REG_WEIGHT_THRESHOLD = 1'b0;

  localparam logic [WEIGHT_W-1:0] THRESHOLD_RESET = 16'd32768;

  typedef struct packed {
    logic                    op;
    logic [CLUSTER_IN_W-1:0] cluster_sl0;
    logic [CLUSTER_IN_W-1:0] cluster_sl1;
    logic [CLUSTER_IN_W-1:0] cluster_sl2;
    logic [CLUSTER_IN_W-1:0] cluster_sl3;
    logic [CLUSTER_IN_W-1:0] cluster_sl4;
    logic [CLUSTER_IN_W-1:0] cluster_sl5;
    logic [WEIGHT_W-1:0]     track_weight;
  } cand_t;

  typedef struct packed {
    logic [TRACK_INDEX_W-1:0] track_index;
    logic [STATUS_W-1:0]      track_status;
    logic                     last;
    logic                     dropped;
  } result_t;

endpackage

### design/greedy_track_overlap_suppression.sv
// ----------------------------------------------------------------------------
// greedy_track_overlap_suppression
// Greedy overlap suppression of track candidates held in on-chip RAM.
// ----------------------------------------------------------------------------
//
//  channel   | signals                         | handshake
//  ----------+---------------------------------+------------------------------
//  item in   | cand (cand_t)                   | start && !busy
//  result    | result (result_t)               | result_valid, one cycle each
//  config    | psel penable pwrite paddr pwdata| write on psel&penable&pwrite
//            | prdata pready                   | pready tied high
//
//  Load: one item per cycle, busy stays low.
//  Run: each sweep over a store of n tracks (n > 0) reads the entries in turn,
//  waits for the last read data, then decides. An initial pick sweep, then for
//  each selected track a fetch (mark it and read its cluster ids) and a capture
//  (latch them) plus a fused suppress/pick sweep, then an emit sweep. An empty
//  run passes through one sweep and the emit state and emits nothing.
//  Each RAM has a single read port, so a sweep reads one entry at a time.
//  Reset (rst, synchronous) clears control state; RAM contents are not reset.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module greedy_track_overlap_suppression #(
  parameter int MAX_TRACKS      = 64,
  parameter int SUPERLAYERS     = 6,
  parameter int CLUSTER_ID_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  gtos_pkg::cand_t  cand,
  output logic             result_valid,
  output gtos_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW    = $clog2(MAX_TRACKS + 1);
  localparam int IDS_W = SUPERLAYERS * CLUSTER_ID_BITS;
  localparam int TRK_W = IDS_W + gtos_pkg::WEIGHT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,    // pick sweep, with suppression once a track is selected
    S_FETCH,    // mark best selected, read its cluster ids
    S_CAPTURE,  // latch best cluster ids
    S_EMIT      // stream statuses
  } state_t;

  typedef logic [SUPERLAYERS-1:0][CLUSTER_ID_BITS-1:0] ids_t;

  state_t                          state;
  logic [CW-1:0]                   count;
  logic                            overflow;
  logic [gtos_pkg::WEIGHT_W-1:0]   threshold;

  // sweep pipeline
  logic [CW-1:0]                   rd_idx;
  logic                            s_vld;
  logic [AW-1:0]                   s_idx;
  logic                            sup_en;
  logic                            first_pick;
  logic                            reject_all;

  // running best
  logic                            found;
  logic [AW-1:0]                   best_idx;
  logic [gtos_pkg::WEIGHT_W-1:0]   best_w;
  ids_t                            best_ids;

  // RAM ports
  logic                            trk_we;
  logic [AW-1:0]                   trk_waddr;
  logic [TRK_W-1:0]                trk_wdata;
  logic [AW-1:0]                   raddr;
  logic [TRK_W-1:0]                trk_rdata;
  logic                            st_we;
  logic [AW-1:0]                   st_waddr;
  logic [gtos_pkg::STATUS_W-1:0]   st_wdata;
  logic [gtos_pkg::STATUS_W-1:0]   st_rdata;

  logic [gtos_pkg::CLUSTER_IN_W-1:0] cand_ids [6];
  ids_t                            load_ids;
  ids_t                            rd_ids;
  logic [gtos_pkg::WEIGHT_W-1:0]   rd_weight;

  logic                            accept;
  logic                            do_load;
  logic                            store_full;
  logic                            rd_go;
  logic                            shares;
  logic                            hit;
  logic                            pick_ok;
  logic                            cfg_wr;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  assign prdata = (paddr[2] == gtos_pkg::REG_WEIGHT_THRESHOLD) ?
                  {16'b0, threshold} : 32'b0;

  assign store_full = (count >= CW'(MAX_TRACKS));
  assign do_load    = accept && (cand.op == gtos_pkg::OP_LOAD) && !store_full;

  // incoming cluster ids, masked/extended to the stored width
  assign cand_ids[0] = cand.cluster_sl0;
  assign cand_ids[1] = cand.cluster_sl1;
  assign cand_ids[2] = cand.cluster_sl2;
  assign cand_ids[3] = cand.cluster_sl3;
  assign cand_ids[4] = cand.cluster_sl4;
  assign cand_ids[5] = cand.cluster_sl5;

  always_comb begin
    for (int s = 0; s < SUPERLAYERS; s++) begin
      load_ids[s] = CLUSTER_ID_BITS'(cand_ids[s]);
    end
  end

  assign rd_ids    = trk_rdata[TRK_W-1:gtos_pkg::WEIGHT_W];
  assign rd_weight = trk_rdata[gtos_pkg::WEIGHT_W-1:0];

  // sweep issues one read per cycle until the stored count is reached
  assign rd_go = ((state == S_SWEEP) || (state == S_EMIT)) && (rd_idx < count);
  assign raddr = (state == S_FETCH) ? best_idx : rd_idx[AW-1:0];

  always_comb begin
    shares = 1'b0;
    for (int s = 0; s < SUPERLAYERS; s++) begin
      if (rd_ids[s] == best_ids[s]) begin
        shares = 1'b1;
      end
    end
  end

  // suppression and next pick fused: a rejected entry cannot be picked
  assign hit     = (state == S_SWEEP) && s_vld && sup_en &&
                   (st_rdata == gtos_pkg::ST_UNASSIGNED) && shares;
  assign pick_ok = (state == S_SWEEP) && s_vld && !hit &&
                   (st_rdata == gtos_pkg::ST_UNASSIGNED) && (rd_weight > best_w);

  assign trk_we    = do_load;
  assign trk_waddr = count[AW-1:0];
  assign trk_wdata = {load_ids, cand.track_weight};

  always_comb begin
    st_we    = 1'b0;
    st_waddr = count[AW-1:0];
    st_wdata = gtos_pkg::ST_UNASSIGNED;
    if (do_load) begin
      st_we = 1'b1;
    end else if (state == S_FETCH) begin
      st_we    = 1'b1;
      st_waddr = best_idx;
      st_wdata = gtos_pkg::ST_SELECTED;
    end else if (hit) begin
      st_we    = 1'b1;
      st_waddr = s_idx;
      st_wdata = gtos_pkg::ST_REJECTED;
    end
  end

  gtos_ram #(.WIDTH(TRK_W), .DEPTH(MAX_TRACKS)) u_trk_ram (
    .clk   (clk),
    .we    (trk_we),
    .waddr (trk_waddr),
    .wdata (trk_wdata),
    .raddr (raddr),
    .rdata (trk_rdata)
  );

  gtos_ram #(.WIDTH(gtos_pkg::STATUS_W), .DEPTH(MAX_TRACKS)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      overflow     <= 1'b0;
      threshold    <= gtos_pkg::THRESHOLD_RESET;
      result_valid <= 1'b0;
      s_vld        <= 1'b0;
      found        <= 1'b0;
    end else begin
      result_valid <= 1'b0;

      if (cfg_wr && (paddr[2] == gtos_pkg::REG_WEIGHT_THRESHOLD)) begin
        threshold <= pwdata[gtos_pkg::WEIGHT_W-1:0];
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cand.op == gtos_pkg::OP_LOAD) begin
              if (store_full) begin
                overflow <= 1'b1;
              end else begin
                count <= count + CW'(1);
              end
            end else begin
              rd_idx     <= '0;
              s_vld      <= 1'b0;
              sup_en     <= 1'b0;
              first_pick <= 1'b1;
              found      <= 1'b0;
              best_w     <= threshold;
              state      <= S_SWEEP;
            end
          end
        end

        S_SWEEP: begin
          s_vld <= rd_go;
          s_idx <= rd_idx[AW-1:0];
          if (rd_go) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (pick_ok) begin
            best_w   <= rd_weight;
            best_idx <= s_idx;
            found    <= 1'b1;
          end
          if (!rd_go && !s_vld) begin
            if (found) begin
              state <= S_FETCH;
            end else begin
              // nothing qualified on the very first pass: reject everything
              reject_all <= first_pick;
              rd_idx     <= '0;
              state      <= S_EMIT;
            end
          end
        end

        S_FETCH: begin
          first_pick <= 1'b0;
          state      <= S_CAPTURE;
        end

        S_CAPTURE: begin
          best_ids <= rd_ids;
          sup_en   <= 1'b1;
          found    <= 1'b0;
          best_w   <= threshold;
          rd_idx   <= '0;
          state    <= S_SWEEP;
        end

        S_EMIT: begin
          s_vld <= rd_go;
          s_idx <= rd_idx[AW-1:0];
          if (rd_go) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (s_vld) begin
            result_valid        <= 1'b1;
            result.track_index  <= gtos_pkg::TRACK_INDEX_W'(s_idx);
            result.track_status <= reject_all ? gtos_pkg::ST_REJECTED : st_rdata;
            result.last         <= ((CW'(s_idx) + CW'(1)) == count);
            result.dropped      <= overflow;
          end
          if (!rd_go && !s_vld) begin
            count    <= '0;
            overflow <= 1'b0;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // results only stream out during the emit sweep
  a_result_in_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == S_EMIT))
    else $error("result strobe outside emit sweep");

  // store count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TRACKS))
    else $error("track count above capacity");

  // nothing follows the last status of a run
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("result after last");

  // a track is only marked selected when a pick was found
  a_fetch_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> found)
    else $error("select without a pick");

endmodule

### design/gtos_ram.sv
// ----------------------------------------------------------------------------
// gtos_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gtos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for greedy_track_overlap_suppression. Random and
// directed track loads and runs are sent over start/busy. A scoreboard repeats
// the greedy pass and checks every status item.
// ----------------------------------------------------------------------------
module tb;

  localparam int TRACK_SLOTS   = 64;
  localparam int SL_COUNT      = 6;
  localparam int STALL_LIMIT   = 50000;  // covers the longest run with no item
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] THRESHOLD_ADDR = {gtos_pkg::REG_WEIGHT_THRESHOLD, 2'b00};

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the track store, the greedy pass, and the queue of
  // status items still to come from the block.
  // --------------------------------------------------------------------------
  class track_status_board;
    logic [gtos_pkg::WEIGHT_W-1:0]     threshold;
    logic [gtos_pkg::CLUSTER_IN_W-1:0] cluster_ids [TRACK_SLOTS][SL_COUNT];
    logic [gtos_pkg::WEIGHT_W-1:0]     weights [TRACK_SLOTS];
    logic [gtos_pkg::STATUS_W-1:0]     statuses [TRACK_SLOTS];
    int                                track_count;
    bit                                overflow;
    gtos_pkg::result_t                 pending_statuses [$];
    int                                errors;

    function new();
      threshold   = gtos_pkg::THRESHOLD_RESET;
      track_count = 0;
      overflow    = 0;
      errors      = 0;
    endfunction

    // heaviest unassigned track strictly above threshold, lowest index on ties
    function int strongest_open_track();
      int best;
      logic [gtos_pkg::WEIGHT_W-1:0] best_w;
      best   = -1;
      best_w = threshold;
      for (int i = 0; i < track_count; i++) begin
        if (statuses[i] == gtos_pkg::ST_UNASSIGNED && weights[i] > best_w) begin
          best_w = weights[i];
          best   = i;
        end
      end
      return best;
    endfunction

    function bit shares_cluster(int a, int b);
      for (int s = 0; s < SL_COUNT; s++) begin
        if (cluster_ids[a][s] == cluster_ids[b][s]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void resolve_overlaps();
      int best;
      gtos_pkg::result_t r;
      best = strongest_open_track();
      // nothing qualifies at all: whole store is rejected
      if (best < 0) begin
        for (int i = 0; i < track_count; i++) statuses[i] = gtos_pkg::ST_REJECTED;
      end
      while (best >= 0) begin
        statuses[best] = gtos_pkg::ST_SELECTED;
        for (int i = 0; i < track_count; i++) begin
          if (statuses[i] == gtos_pkg::ST_UNASSIGNED && shares_cluster(best, i))
            statuses[i] = gtos_pkg::ST_REJECTED;
        end
        best = strongest_open_track();
      end
      for (int i = 0; i < track_count; i++) begin
        r.track_index  = gtos_pkg::TRACK_INDEX_W'(i);
        r.track_status = statuses[i];
        r.last         = (i == track_count - 1);
        r.dropped      = overflow;
        pending_statuses = {pending_statuses, r};
      end
      track_count = 0;
      overflow    = 1'b0;
    endfunction

    function void note_item(gtos_pkg::cand_t c);
      if (c.op == gtos_pkg::OP_LOAD) begin
        if (track_count >= TRACK_SLOTS) begin
          overflow = 1'b1;
        end else begin
          cluster_ids[track_count][0] = c.cluster_sl0;
          cluster_ids[track_count][1] = c.cluster_sl1;
          cluster_ids[track_count][2] = c.cluster_sl2;
          cluster_ids[track_count][3] = c.cluster_sl3;
          cluster_ids[track_count][4] = c.cluster_sl4;
          cluster_ids[track_count][5] = c.cluster_sl5;
          weights[track_count]        = c.track_weight;
          statuses[track_count]       = gtos_pkg::ST_UNASSIGNED;
          track_count++;
        end
      end else begin
        resolve_overlaps();
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_status(gtos_pkg::result_t r);
      gtos_pkg::result_t e;
      if (pending_statuses.size() == 0) begin
        $error("status item with none expected: index %0d status %0d",
               r.track_index, r.track_status);
        errors++;
        return;
      end
      e = pending_statuses.pop_front();
      compare_field("track_index", e.track_index, r.track_index);
      compare_field("track_status", e.track_status, r.track_status);
      compare_field("last", e.last, r.last);
      compare_field("dropped", e.dropped, r.dropped);
    endfunction

    function void check_drained();
      if (pending_statuses.size() != 0) begin
        $error("%0d status items never arrived", pending_statuses.size());
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  gtos_pkg::cand_t   cand;
  logic              result_valid;
  gtos_pkg::result_t result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  track_status_board board = new();
  int idle_pct;
  int stall_cycles;

  greedy_track_overlap_suppression DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cand         (cand),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Monitor: everything is sampled at the rising edge (pre-update values).
  // An item in is noted before a status item in the same cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_item(cand);
      if (result_valid) board.check_status(result);
      if (psel && penable && pwrite && pready && paddr == THRESHOLD_ADDR)
        board.threshold = pwdata[gtos_pkg::WEIGHT_W-1:0];
    end
  end

  // Watchdog: cycles with no item in, no status out and no register access.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("greedy_track_overlap_suppression: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge only
  // --------------------------------------------------------------------------
  task automatic send_item(input gtos_pkg::cand_t c);
    // random sender gaps; start drops only on gap cycles
    while ($urandom_range(1, 100) <= idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    cand  <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every status item is in and the block is idle
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending_statuses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);  // an empty run emits nothing
    while (busy) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [gtos_pkg::WEIGHT_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    // read back in the next transfer
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[gtos_pkg::WEIGHT_W-1:0] != value) begin
      $error("weight_threshold: expected %0d, actual %0d", value,
             prdata[gtos_pkg::WEIGHT_W-1:0]);
      board.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic gtos_pkg::cand_t track_item(input logic [gtos_pkg::WEIGHT_W-1:0] w,
                                                 input logic [8*SL_COUNT-1:0] ids);
    gtos_pkg::cand_t c;
    c.op          = gtos_pkg::OP_LOAD;
    c.cluster_sl0 = ids[47:40];
    c.cluster_sl1 = ids[39:32];
    c.cluster_sl2 = ids[31:24];
    c.cluster_sl3 = ids[23:16];
    c.cluster_sl4 = ids[15:8];
    c.cluster_sl5 = ids[7:0];
    c.track_weight = w;
    return c;
  endfunction

  // small cluster ids most of the time so tracks overlap often
  function automatic logic [gtos_pkg::CLUSTER_IN_W-1:0] random_cluster();
    if ($urandom_range(0, 2) == 0) return gtos_pkg::CLUSTER_IN_W'($urandom_range(0, 255));
    return gtos_pkg::CLUSTER_IN_W'($urandom_range(0, 3));
  endfunction

  function automatic gtos_pkg::cand_t random_track();
    gtos_pkg::cand_t c;
    int w;
    c = gtos_pkg::cand_t'($urandom());
    c.op          = gtos_pkg::OP_LOAD;
    c.cluster_sl0 = random_cluster();
    c.cluster_sl1 = random_cluster();
    c.cluster_sl2 = random_cluster();
    c.cluster_sl3 = random_cluster();
    c.cluster_sl4 = random_cluster();
    c.cluster_sl5 = random_cluster();
    case ($urandom_range(0, 3))
      0: w = $urandom_range(0, 65535);
      1: w = int'(board.threshold) + $urandom_range(0, 4) - 2;  // hug the threshold
      2: w = $urandom_range(32768, 65535);
      default: w = $urandom_range(0, 32767);
    endcase
    if (w < 0) w = 0;
    if (w > 65535) w = 65535;
    c.track_weight = gtos_pkg::WEIGHT_W'(w);
    return c;
  endfunction

  // run item with junk in the unused fields
  function automatic gtos_pkg::cand_t run_item();
    gtos_pkg::cand_t c;
    c    = gtos_pkg::cand_t'({$urandom(), $urandom(), $urandom()});
    c.op = gtos_pkg::OP_RUN;
    return c;
  endfunction

  task automatic send_batch(input int n);
    for (int k = 0; k < n; k++) send_item(random_track());
    send_item(run_item());
  endtask

  task automatic random_phase(input int budget, input int pct);
    int sent;
    int n;
    idle_pct = pct;
    sent     = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 19))
        0: n = $urandom_range(TRACK_SLOTS, TRACK_SLOTS + 3);  // full store, maybe drops
        1: n = 0;                                            // empty run
        default: n = $urandom_range(1, 10);
      endcase
      send_batch(n);
      sent += n + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clk      = 1'b0;
    rst      = 1'b1;
    start    = 1'b0;
    cand     = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_pct = 0;
    stall_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset threshold (0.5)
    send_item(run_item());                                  // empty run
    send_item(track_item(16'hFFFF, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}));
    send_item(track_item(16'd40000, {8'd1, 8'd1, 8'd1, 8'd0, 8'd1, 8'd1}));  // overlaps 0
    send_item(track_item(16'd0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}));
    send_item(track_item(16'd32768, {8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2}));  // equal: open
    send_item(track_item(16'd32769, {8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3}));
    send_item(track_item(16'd50000, {8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd7}));  // tie, wins
    send_item(track_item(16'd50000, {8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd7}));  // tie, loses
    send_item(track_item(16'd20000, {8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'hFF}));
    send_item(run_item());
    // nothing above threshold: all rejected
    send_item(track_item(16'd100, {8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}));
    send_item(track_item(16'd32768, {8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}));
    send_item(run_item());
    // single track, then a run right after the store was emptied
    send_item(track_item(16'd32769, {8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04}));
    send_item(run_item());
    send_item(run_item());

    wait_drained();
    write_threshold(16'd0);
    random_phase(20, 0);

    wait_drained();
    write_threshold(16'hFFFF);  // nothing can qualify
    random_phase(12, 51);

    wait_drained();
    write_threshold(gtos_pkg::WEIGHT_W'($urandom_range(1, 65534)));
    idle_pct = 23;
    send_batch(TRACK_SLOTS + 2);  // guaranteed overflow
    random_phase(10, 23);

    wait_drained();
    write_threshold(gtos_pkg::THRESHOLD_RESET);
    random_phase(15, 0);

    wait_drained();
    board.check_drained();
    if (board.errors == 0) begin
      $display("greedy_track_overlap_suppression: match");
    end else begin
      $display("greedy_track_overlap_suppression: mismatch");
    end
    $finish;
  end

endmodule

### greedy_track_overlap_suppression.f
design/gtos_pkg.sv
design/gtos_ram.sv
design/greedy_track_overlap_suppression.sv
test/tb.sv
